>>> hw/rtl/pdc_pkg.sv
package pdc_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int NUM_CODES    = 7;

    // CRC-8/BLUETOOTH, reflected form of polynomial 0xa7
    localparam logic [7:0] CRC_POLY_REFL = 8'he5;
    localparam logic [7:0] CRC_INIT      = 8'h00;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ACKNOWLEDGE = 3'd0;
    localparam cfg_idx_t CFG_COMMAND     = 3'd1;
    localparam cfg_idx_t CFG_DATA        = 3'd2;
    localparam cfg_idx_t CFG_DEBUG       = 3'd3;
    localparam cfg_idx_t CFG_HEARTBEAT   = 3'd4;
    localparam cfg_idx_t CFG_INFO        = 3'd5;
    localparam cfg_idx_t CFG_ERROR       = 3'd6;

    typedef logic [NUM_CODES-1:0][7:0] code_array_t;

    localparam code_array_t CODE_RESET = {8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  method_byte;
        logic [31:0] node_id;
        logic [15:0] seq_number;
        logic [7:0]  header_crc;
        logic [15:0] payload_length;
        logic [7:0]  computed_crc;
        logic        flag_ok;
        logic        crc_ok;
        logic        terminator_ok;
    } res_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/pdc_cfg.sv
module pdc_cfg
    import pdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [7:0]  cfg_data,
    output code_array_t codes
);

    code_array_t codes_reg;
    code_array_t codes_next;

    assign cfg_ready = 1'b1;
    assign codes     = codes_reg;

    always_comb
    begin
        codes_next = codes_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ACKNOWLEDGE: codes_next[CFG_ACKNOWLEDGE] = cfg_data;
                CFG_COMMAND:     codes_next[CFG_COMMAND]     = cfg_data;
                CFG_DATA:        codes_next[CFG_DATA]        = cfg_data;
                CFG_DEBUG:       codes_next[CFG_DEBUG]       = cfg_data;
                CFG_HEARTBEAT:   codes_next[CFG_HEARTBEAT]   = cfg_data;
                CFG_INFO:        codes_next[CFG_INFO]        = cfg_data;
                CFG_ERROR:       codes_next[CFG_ERROR]       = cfg_data;
                default:         codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            codes_reg <= CODE_RESET;
        else
            codes_reg <= codes_next;
    end

endmodule

>>> hw/rtl/pdc_parse.sv
module pdc_parse
    import pdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_accept,
    input  logic [7:0]  rx_byte,
    input  logic        start_mark,
    input  code_array_t codes,
    output logic        res_valid,
    output res_t        res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TERM
    } phase_t;

    localparam logic [HDR_IDX_W-1:0] IDX_METHOD    = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] IDX_NODE_LAST = HDR_IDX_W'(4);
    localparam logic [HDR_IDX_W-1:0] IDX_SEQ_LAST  = HDR_IDX_W'(6);
    localparam logic [HDR_IDX_W-1:0] IDX_CRC       = HDR_IDX_W'(7);
    localparam logic [HDR_IDX_W-1:0] IDX_LEN_HI    = HDR_IDX_W'(8);

    phase_t      phase_reg,       phase_next,  eff_phase;
    logic [15:0] byte_count_reg,  count_next,  eff_count;
    logic [7:0]  held_method_reg, method_next;
    logic [31:0] held_node_reg,   node_next,   eff_node;
    logic [15:0] held_seq_reg,    seq_next,    eff_seq;
    logic [7:0]  held_hcrc_reg,   hcrc_next,   eff_hcrc;
    logic [15:0] held_len_reg,    len_next,    eff_len;
    logic [7:0]  crc_reg,         crc_next,    eff_crc;
    logic [15:0] count_inc;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic        method_match;

    always_comb
    begin
        // a start mark drops whatever packet is in progress
        eff_phase = phase_reg;
        eff_count = byte_count_reg;
        eff_node  = held_node_reg;
        eff_seq   = held_seq_reg;
        eff_hcrc  = held_hcrc_reg;
        eff_len   = held_len_reg;
        eff_crc   = crc_reg;
        if (start_mark)
        begin
            eff_phase = PH_HEADER;
            eff_count = '0;
            eff_node  = '0;
            eff_seq   = '0;
            eff_hcrc  = '0;
            eff_len   = '0;
            eff_crc   = CRC_INIT;
        end

        count_inc = eff_count + 16'd1;
        hdr_idx   = eff_count[HDR_IDX_W-1:0];

        method_match = 1'b0;
        for (int i = 0; i < NUM_CODES; i++)
            method_match = method_match | (codes[i] == held_method_reg);

        phase_next  = phase_reg;
        count_next  = byte_count_reg;
        method_next = held_method_reg;
        node_next   = held_node_reg;
        seq_next    = held_seq_reg;
        hcrc_next   = held_hcrc_reg;
        len_next    = held_len_reg;
        crc_next    = crc_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (in_accept)
        begin
            phase_next = eff_phase;
            count_next = eff_count;
            node_next  = eff_node;
            seq_next   = eff_seq;
            hcrc_next  = eff_hcrc;
            len_next   = eff_len;
            crc_next   = eff_crc;

            unique case (eff_phase)
                PH_HEADER:
                begin
                    if (hdr_idx == IDX_METHOD)
                        method_next = rx_byte;
                    else if (hdr_idx <= IDX_NODE_LAST)
                        node_next = {eff_node[23:0], rx_byte};
                    else if (hdr_idx <= IDX_SEQ_LAST)
                        seq_next = {eff_seq[7:0], rx_byte};
                    else if (hdr_idx == IDX_CRC)
                        hcrc_next = rx_byte;
                    else if (hdr_idx == IDX_LEN_HI)
                        len_next = {rx_byte, 8'h00};
                    else
                        len_next = {eff_len[15:8], rx_byte};

                    count_next = count_inc;
                    if (count_inc >= 16'(HEADER_BYTES))
                    begin
                        count_next = '0;
                        phase_next = (len_next == 16'd0) ? PH_TERM : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next   = crc8_update(eff_crc, rx_byte);
                    count_next = count_inc;
                    if (count_inc >= eff_len)
                    begin
                        count_next = '0;
                        phase_next = PH_TERM;
                    end
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                end
                PH_TERM:
                begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_REPORT;
                    res.method_byte    = held_method_reg;
                    res.node_id        = eff_node;
                    res.seq_number     = eff_seq;
                    res.header_crc     = eff_hcrc;
                    res.payload_length = eff_len;
                    res.computed_crc   = eff_crc;
                    res.flag_ok        = method_match;
                    res.crc_ok         = (eff_crc == eff_hcrc);
                    res.terminator_ok  = (rx_byte == 8'h00);
                    phase_next         = PH_IDLE;
                    count_next         = '0;
                end
                PH_IDLE:
                begin
                    // drop bytes outside a packet
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_count_reg  <= '0;
            held_method_reg <= '0;
            held_node_reg   <= '0;
            held_seq_reg    <= '0;
            held_hcrc_reg   <= '0;
            held_len_reg    <= '0;
            crc_reg         <= CRC_INIT;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_count_reg  <= count_next;
            held_method_reg <= method_next;
            held_node_reg   <= node_next;
            held_seq_reg    <= seq_next;
            held_hcrc_reg   <= hcrc_next;
            held_len_reg    <= len_next;
            crc_reg         <= crc_next;
        end
    end

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> byte_count_reg < 16'(HEADER_BYTES))
        else $error("header byte count out of range");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> byte_count_reg < held_len_reg)
        else $error("payload byte count reached length");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_TERM) |-> byte_count_reg == 16'd0)
        else $error("byte count not cleared");

    a_payload_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !start_mark && phase_reg == PH_PAYLOAD
            |-> res_valid && res.kind == KIND_PAYLOAD && res.payload_byte == rx_byte)
        else $error("payload word not passed on");

endmodule

>>> hw/rtl/pdc_out_reg.sv
module pdc_out_reg
    import pdc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t res,
    output logic can_take,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg,   out_res_next;

    // a new word may enter while the held one leaves in the same cycle
    assign can_take  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> can_take)
        else $error("result pushed over a held word");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("held result word changed");

    a_pushed_word: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg && out_res_reg == $past(res))
        else $error("pushed word not presented");

endmodule

>>> hw/rtl/packet_deframer_crc8_check.sv
// Packet deframer with CRC-8/BLUETOOTH payload check. Feed one received byte per
// input word; start_mark on a byte restarts parsing with it as the method byte of a
// 10-byte big-endian header (method, node id, sequence, CRC, payload length). Each
// payload byte comes out as a kind 0 word, and the terminator byte after the payload
// yields one kind 1 report with the header fields, the computed CRC and the method,
// CRC and terminator verdicts. The block takes one byte every cycle: parsing and the
// byte-wide CRC update are combinational from the parser state, and results sit in
// a single output register, so in_ready drops only while that register holds a word
// that out_ready has not taken. A result appears in the cycle after its byte.
// The method-code registers are written over cfg_* (index 0..6, cfg_ready is always
// high, other indexes are ignored) and should change only while no packet is open.
module packet_deframer_crc8_check
    import pdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        start_mark,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  method_byte,
    output logic [31:0] node_id,
    output logic [15:0] seq_number,
    output logic [7:0]  header_crc,
    output logic [15:0] payload_length,
    output logic [7:0]  computed_crc,
    output logic        flag_ok,
    output logic        crc_ok,
    output logic        terminator_ok,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    code_array_t codes;
    logic        in_accept;
    logic        res_valid;
    res_t        res;
    res_t        out_res;

    assign in_accept = in_valid && in_ready;

    pdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .codes     (codes)
    );

    pdc_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .rx_byte    (rx_byte),
        .start_mark (start_mark),
        .codes      (codes),
        .res_valid  (res_valid),
        .res        (res)
    );

    pdc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .res       (res),
        .can_take  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind           = out_res.kind;
    assign payload_byte   = out_res.payload_byte;
    assign method_byte    = out_res.method_byte;
    assign node_id        = out_res.node_id;
    assign seq_number     = out_res.seq_number;
    assign header_crc     = out_res.header_crc;
    assign payload_length = out_res.payload_length;
    assign computed_crc   = out_res.computed_crc;
    assign flag_ok        = out_res.flag_ok;
    assign crc_ok         = out_res.crc_ok;
    assign terminator_ok  = out_res.terminator_ok;

    a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_accept)
        else $error("result without an accepted byte");

    a_report_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_REPORT |-> payload_byte == 8'h00)
        else $error("report carries a payload byte");

    a_payload_zero_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PAYLOAD |-> node_id == 32'd0 && !flag_ok && !crc_ok)
        else $error("payload word carries report fields");

endmodule
